// File: sv/fir32_pkg.sv
// ----------------------------------------------------------------------------
// fir32_pkg
// Shared constants, the coefficient table, the microcode word and the
// microprogram of the 32-tap sample filter.
// ----------------------------------------------------------------------------
package fir32_pkg;

    // Default sizes
    localparam int DEF_TAPS        = 32;
    localparam int DEF_SAMPLE_BITS = 12;
    localparam int DEF_WEIGHT_BITS = 32;

    // Coefficient table: unsigned Q1.31, entry k weights the sample delayed by TAPS-1-k
    localparam int ROM_DEPTH = 32;
    localparam int ROM_BITS  = 32;

    localparam logic [ROM_BITS-1:0] WEIGHT_ROM [ROM_DEPTH] = '{
        32'd2291,      32'd5101,      32'd9403,      32'd16001,     32'd25464,
        32'd38051,     32'd53614,     32'd71498,     32'd90428,     32'd108419,
        32'd122728,    32'd129871,    32'd125727,    32'd105754,    32'd65289,
        32'd10745553,  32'd12002313,  32'd15869677,  32'd22172514,  32'd30629725,
        32'd40866756,  32'd52432148,  32'd64817358,  32'd77478988,  32'd89862469,
        32'd101426172, 32'd111664921, 32'd120131893, 32'd126457991, 32'd130367841,
        32'd131691727, 32'd130367841
    };

    // Taps past the end of the table weigh zero
    function automatic logic [ROM_BITS-1:0] weight_at(input logic [7:0] k);
        logic [ROM_BITS-1:0] w;
        w = '0;
        if (k < 8'(ROM_DEPTH)) begin
            w = WEIGHT_ROM[k[4:0]];
        end
        return w;
    endfunction

    // Microprogram step addresses
    localparam int STEP_W = 2;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_IDLE  = 2'd0;
    localparam step_t STEP_ISSUE = 2'd1;
    localparam step_t STEP_DRAIN = 2'd2;
    localparam step_t STEP_EMIT  = 2'd3;

    // Jump conditions
    typedef enum logic [1:0] {
        COND_NO_INPUT  = 2'd0,
        COND_MORE_TAPS = 2'd1,
        COND_PIPE_BUSY = 2'd2,
        COND_OUT_BUSY  = 2'd3
    } cond_t;

    // One control word
    typedef struct packed {
        logic  take;    // offer s_tready, load the request on handshake
        logic  issue;   // send one tap into the multiply-accumulate pipe
        logic  emit;    // load the result register, store the sample
        cond_t cond;    // when true, jump to target
        step_t target;  // otherwise fall through to the next step
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic in_valid;
        logic more_taps;
        logic pipe_busy;
        logic out_busy;
    } status_t;

    // The program; the last step falls through back to step zero
    localparam ctrl_t PROGRAM [4] = '{
        '{take: 1'b1, issue: 1'b0, emit: 1'b0, cond: COND_NO_INPUT,  target: STEP_IDLE},
        '{take: 1'b0, issue: 1'b1, emit: 1'b0, cond: COND_MORE_TAPS, target: STEP_ISSUE},
        '{take: 1'b0, issue: 1'b0, emit: 1'b0, cond: COND_PIPE_BUSY, target: STEP_DRAIN},
        '{take: 1'b0, issue: 1'b0, emit: 1'b1, cond: COND_OUT_BUSY,  target: STEP_EMIT}
    };

endpackage

// File: sv/fir32_seq.sv
// ----------------------------------------------------------------------------
// fir32_seq
// Microcode sequencer: step counter, program table lookup and conditional
// jumps on datapath status.
// ----------------------------------------------------------------------------
module fir32_seq (
    input  logic                aclk,
    input  logic                aresetn,
    input  fir32_pkg::status_t  status,
    output fir32_pkg::ctrl_t    ctrl
);

    fir32_pkg::step_t pc_reg;
    fir32_pkg::step_t pc_next;
    logic             jump;

    // Fetch the current control word
    assign ctrl = fir32_pkg::PROGRAM[pc_reg];

    // Evaluate the jump condition
    always_comb begin
        unique case (ctrl.cond)
            fir32_pkg::COND_NO_INPUT:  jump = !status.in_valid;
            fir32_pkg::COND_MORE_TAPS: jump = status.more_taps;
            fir32_pkg::COND_PIPE_BUSY: jump = status.pipe_busy;
            fir32_pkg::COND_OUT_BUSY:  jump = status.out_busy;
        endcase
    end

    // Jump or fall through; the step counter wraps after the last step
    assign pc_next = jump ? ctrl.target : pc_reg + fir32_pkg::step_t'(1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= fir32_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

// File: sv/fir32_dp.sv
// ----------------------------------------------------------------------------
// fir32_dp
// Datapath: sample history memory, coefficient lookup, shared multiplier and
// accumulator, scaling with saturation, and the result register.
// ----------------------------------------------------------------------------
module fir32_dp #(
    parameter int TAPS        = fir32_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = fir32_pkg::DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS = fir32_pkg::DEF_WEIGHT_BITS,
    parameter int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fir32_pkg::ctrl_t    ctrl,
    output fir32_pkg::status_t  status,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [DATA_W-1:0]   m_tdata
);

    localparam int HIST   = TAPS - 1;
    localparam int PTR_W  = (HIST > 1) ? $clog2(HIST) : 1;
    localparam int TAP_W  = $clog2(TAPS);
    localparam int PROD_W = WEIGHT_BITS + SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + $clog2(TAPS);
    localparam int Y_W    = ACC_W - (WEIGHT_BITS - 1);

    // History memory and its per-entry valid bits
    logic [SAMPLE_BITS-1:0] hist_mem [HIST];
    logic [HIST-1:0]        valid_reg;
    logic [SAMPLE_BITS-1:0] rd_data_reg;

    logic [SAMPLE_BITS-1:0] x_reg;
    logic [TAP_W-1:0]       d_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [PTR_W-1:0]       wr_slot_reg;

    // Pipe stage B: operands
    logic                   b_valid_reg;
    logic                   b_use_x_reg;
    logic                   b_vbit_reg;
    logic [WEIGHT_BITS-1:0] b_weight_reg;
    // Pipe stage C: product
    logic                   c_valid_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]       acc_reg;

    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] out_data_reg;

    logic                      take;
    logic                      emit;
    logic                      out_busy;
    logic [TAP_W-1:0]          k_tap;
    logic [fir32_pkg::ROM_BITS-1:0] w_full;
    logic [SAMPLE_BITS-1:0]    sample_b;
    logic [PROD_W-1:0]         prod_next;
    logic [PTR_W-1:0]          rd_ptr_init;
    logic [PTR_W-1:0]          rd_ptr_dec;
    logic [PTR_W-1:0]          wr_slot_inc;
    logic [Y_W-1:0]            y_val;
    logic [SAMPLE_BITS-1:0]    filtered;

    // Handshake qualifiers
    assign out_busy = out_valid_reg && !m_tready;
    assign take     = ctrl.take && s_tvalid;
    assign emit     = ctrl.emit && !out_busy;
    assign s_tready = ctrl.take;

    assign status.in_valid  = s_tvalid;
    assign status.more_taps = d_reg != TAP_W'(TAPS - 1);
    assign status.pipe_busy = b_valid_reg || c_valid_reg;
    assign status.out_busy  = out_busy;

    // Weight for delay d is table entry TAPS-1-d, scaled to WEIGHT_BITS
    assign k_tap  = TAP_W'(TAPS - 1) - d_reg;
    assign w_full = fir32_pkg::weight_at(8'(k_tap));

    // Circular pointer arithmetic over the history
    assign rd_ptr_init = (wr_slot_reg == '0) ? PTR_W'(HIST - 1) : wr_slot_reg - PTR_W'(1);
    assign rd_ptr_dec  = (rd_ptr_reg == '0) ? PTR_W'(HIST - 1) : rd_ptr_reg - PTR_W'(1);
    assign wr_slot_inc = (wr_slot_reg == PTR_W'(HIST - 1)) ? '0 : wr_slot_reg + PTR_W'(1);

    // Tap counter and read pointer
    always_ff @(posedge aclk) begin
        if (take) begin
            x_reg      <= s_tdata[SAMPLE_BITS-1:0];
            d_reg      <= '0;
            rd_ptr_reg <= rd_ptr_init;
        end else if (ctrl.issue) begin
            d_reg <= d_reg + TAP_W'(1);
            if (d_reg != '0) begin
                rd_ptr_reg <= rd_ptr_dec;
            end
        end
    end

    // History memory: registered read, write on emit
    always_ff @(posedge aclk) begin
        rd_data_reg <= hist_mem[rd_ptr_reg];
        if (emit) begin
            hist_mem[wr_slot_reg] <= x_reg;
        end
    end

    // Valid bits and write slot
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg   <= '0;
            wr_slot_reg <= '0;
        end else if (emit) begin
            valid_reg[wr_slot_reg] <= 1'b1;
            wr_slot_reg            <= wr_slot_inc;
        end
    end

    // Stage B operands
    always_ff @(posedge aclk) begin
        b_use_x_reg  <= d_reg == '0;
        b_vbit_reg   <= valid_reg[rd_ptr_reg];
        b_weight_reg <= w_full[fir32_pkg::ROM_BITS-1 -: WEIGHT_BITS];
    end

    // Unwritten history entries read as zero
    assign sample_b  = b_use_x_reg ? x_reg : (b_vbit_reg ? rd_data_reg : '0);
    assign prod_next = PROD_W'(b_weight_reg) * PROD_W'(sample_b);

    // Multiply, then accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (take) begin
            acc_reg <= '0;
        end else if (c_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Pipe valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= ctrl.issue;
            c_valid_reg <= b_valid_reg;
        end
    end

    // Drop the fraction bits, saturate to the sample range
    assign y_val    = acc_reg[ACC_W-1 -: Y_W];
    assign filtered = (|y_val[Y_W-1:SAMPLE_BITS]) ? '1 : y_val[SAMPLE_BITS-1:0];

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= filtered;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);

endmodule

// File: sv/fir32_sample_filter.sv
// ----------------------------------------------------------------------------
// fir32_sample_filter
// 32-tap direct-form FIR filter on unsigned converter samples, run by a
// microcoded sequencer over one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake          Payload
//  s_       in   s_tvalid/s_tready  s_tdata[SAMPLE_BITS-1:0] = sample
//  m_       out  m_tvalid/m_tready  m_tdata[SAMPLE_BITS-1:0] = filtered
//
//  One request goes through load, issue of each tap in turn through the
//  shared multiplier, drain of the multiply pipe and emit, since the single
//  multiply-accumulate unit takes the taps one after another.
//  A new request is taken as soon as the result sits in the output register,
//  even while m_tready is low; a second result waits in the emit step.
//  Reset (aresetn low, synchronous) clears the history valid bits, so the
//  history reads as zero, and drops any pending result.
//
module fir32_sample_filter #(
    parameter int TAPS        = fir32_pkg::DEF_TAPS,
    parameter int SAMPLE_BITS = fir32_pkg::DEF_SAMPLE_BITS,
    parameter int WEIGHT_BITS = fir32_pkg::DEF_WEIGHT_BITS
) (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] s_tdata,   // sample
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata    // filtered
);

    localparam int DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

    fir32_pkg::ctrl_t   ctrl;
    fir32_pkg::status_t status;

    // Sequencer
    fir32_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .status  (status),
        .ctrl    (ctrl)
    );

    // Datapath
    fir32_dp #(
        .TAPS        (TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .WEIGHT_BITS (WEIGHT_BITS),
        .DATA_W      (DATA_W)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .status   (status),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/fir32_checker.sv
// ----------------------------------------------------------------------------
// fir32_checker
// Port-level checks on the sample filter, bound to its top level.
// ----------------------------------------------------------------------------
module fir32_checker #(
    parameter int DATA_W = 16
) (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [DATA_W-1:0] m_tdata
);

    // Reset drops any pending result
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or vanished");

    // One request at a time: no new request is taken while one is issuing its taps
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("request taken while one is in work");

    // A result cannot appear the cycle after a request is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too soon after request");

endmodule

bind fir32_sample_filter fir32_checker #(
    .DATA_W ($bits(m_tdata))
) u_fir32_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stream testbench for the 32-tap sample filter. Samples go in through the
// s_ channel and filtered values are checked in order against a local
// direct-form model of the filter, with random idles on both sides and one
// long output hold-off that backs the filter up.
// ----------------------------------------------------------------------------
module testbench;

    localparam int DATA_W    = 16;
    localparam int FILTER_LEN = 32;
    localparam int RAND_ITEMS = 1700;
    localparam int IDLE_PCT  = 16;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TAIL_CYCLES = 80;

    // ------------------------------------------------------------------------
    // Filter model and ordered store of expected filtered values
    // ------------------------------------------------------------------------
    class fir_scoreboard;
        logic [31:0]       tap_weight [FILTER_LEN];
        logic [11:0]       history [FILTER_LEN];   // index = delay, 0 is newest
        logic [DATA_W-1:0] filtered_q [$];
        int                errors;
        int                reported;

        function new();
            tap_weight = '{
                32'd2291,      32'd5101,      32'd9403,      32'd16001,     32'd25464,
                32'd38051,     32'd53614,     32'd71498,     32'd90428,     32'd108419,
                32'd122728,    32'd129871,    32'd125727,    32'd105754,    32'd65289,
                32'd10745553,  32'd12002313,  32'd15869677,  32'd22172514,  32'd30629725,
                32'd40866756,  32'd52432148,  32'd64817358,  32'd77478988,  32'd89862469,
                32'd101426172, 32'd111664921, 32'd120131893, 32'd126457991, 32'd130367841,
                32'd131691727, 32'd130367841
            };
            foreach (history[i]) history[i] = '0;
            errors   = 0;
            reported = 0;
        endfunction

        // Shift in an accepted sample and queue the value it must produce
        function void note_sample(logic [DATA_W-1:0] data);
            logic [63:0] acc;
            logic [63:0] scaled;
            int          d;
            for (d = FILTER_LEN - 1; d > 0; d--) history[d] = history[d-1];
            history[0] = data[11:0];
            acc = '0;
            // Entry k of the table weights the sample delayed by 31-k
            for (d = 0; d < FILTER_LEN; d++) begin
                acc += 64'(tap_weight[FILTER_LEN-1-d]) * 64'(history[d]);
            end
            scaled = acc >> 31;
            if (scaled > 64'd4095) begin
                scaled = 64'd4095;
            end
            filtered_q.push_back({4'b0, scaled[11:0]});
        endfunction

        function void log_error(string what, logic [DATA_W-1:0] exp_v,
                                logic [DATA_W-1:0] act_v);
            errors++;
            if (reported < 10) begin
                reported++;
                $display("%0t: %s: expected 0x%04h got 0x%04h", $realtime, what,
                         exp_v, act_v);
            end
        endfunction

        // Compare one accepted result with the oldest expectation
        function void check_result(logic [DATA_W-1:0] data);
            logic [DATA_W-1:0] exp_v;
            if (filtered_q.size() == 0) begin
                log_error("filtered value with none pending", '0, data);
            end else begin
                exp_v = filtered_q.pop_front();
                if (data !== exp_v) begin
                    log_error("filtered value mismatch", exp_v, data);
                end
            end
        endfunction

        function int pending();
            return filtered_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and the block
    // ------------------------------------------------------------------------
    logic              aclk;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata;     // sample
    logic              m_tvalid;
    logic              m_tready;
    logic [DATA_W-1:0] m_tdata;     // filtered

    fir_scoreboard sb;
    int            samples_taken;
    logic          tx_calm;

    fir32_sample_filter i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Run limit
    initial begin
        #10ms;
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender: offer one request, with random idle cycles ahead of it
    // ------------------------------------------------------------------------
    task automatic send_sample(input logic [DATA_W-1:0] value);
        @(negedge aclk);
        while (!tx_calm && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        sb.note_sample(value);
        samples_taken++;
    endtask

    // Run of one value with random upper bits, which the block must ignore
    task automatic send_run(input logic [11:0] value, input int count);
        int n;
        for (n = 0; n < count; n++) begin
            send_sample({4'($urandom_range(15)), value});
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, a calm stretch and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (!held && samples_taken >= 300) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (!(samples_taken >= 1300 && samples_taken < 1600) &&
                         $urandom_range(99) < IDLE_PCT) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Check each accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [DATA_W-1:0] directed [25];
        int                i;
        int                mode;
        int                waited;

        sb            = new();
        samples_taken = 0;
        tx_calm       = 1'b0;
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;

        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Zero on cleared history, full scale with upper bits set, then zeros
        // so that sample walks over part of the table, then F000, 0FFF and 1
        directed[0] = 16'h0000;
        directed[1] = 16'hFFFF;
        for (i = 2; i < 22; i++) directed[i] = 16'h0000;
        directed[22] = 16'hF000;
        directed[23] = 16'h0FFF;
        directed[24] = 16'h0001;
        foreach (directed[i]) send_sample(directed[i]);

        // Random part: mostly random bursts, plus full-scale runs that reach
        // the largest sum, long zero runs and impulses
        while (samples_taken < RAND_ITEMS) begin
            tx_calm = (samples_taken >= 900 && samples_taken < 1200);
            mode = $urandom_range(99);
            if (mode < 70) begin
                for (i = $urandom_range(20, 1); i > 0; i--) begin
                    send_sample(DATA_W'($urandom()));
                end
            end else if (mode < 80) begin
                send_run(12'hFFF, $urandom_range(40, 33));
            end else if (mode < 88) begin
                send_run(12'h000, $urandom_range(40, 33));
            end else begin
                send_sample(DATA_W'($urandom()));
                send_run(12'h000, 31);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;

        // Drain, then allow for late or extra results
        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// File: files.f
sv/fir32_pkg.sv
sv/fir32_seq.sv
sv/fir32_dp.sv
sv/fir32_sample_filter.sv
sv/fir32_checker.sv
tb/testbench.sv
